@@ design/scba_pkg.sv @@
// Shared types, result codes and size-class functions for the block allocator.
package scba_pkg;

  localparam int BucketBytesLog = 14;
  localparam int BucketBits = 7;
  localparam int BlockBits = 11;
  localparam int LinkBits = 12;
  localparam int AddrBits = 48;
  localparam logic [15:0] MaxBlockBytes = 16'd16384;

  localparam logic [2:0] ST_ALLOCATED = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_FREED = 3'd3;
  localparam logic [2:0] ST_NOT_OURS = 3'd4;

  typedef struct packed {
    logic       clear;
    logic       latch_in;
    logic       head_rd;
    logic       next_rd;
    logic       div_start;
    logic       alloc_wr;
    logic       free_wr;
    logic       mul;
    logic       addr_calc;
    logic       finish;
    logic [2:0] code;
  } scba_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_free;
    logic too_large;
    logic out_of_heap;
    logic head_valid;
    logic div_busy;
    logic block_ok;
  } scba_sts_t;

  // Block size of a bucket in bytes.
  function automatic logic [14:0] scba_block_size(input logic [6:0] b);
    logic [14:0] t;
    logic [2:0]  r;
    t = 15'(b[3:0]) + 15'd1;
    r = b[6:4] - 3'd1;
    if (b < 7'd32) begin
      scba_block_size = (15'(b) + 15'd1) << 3;
    end else begin
      scba_block_size = (15'd128 << r) + (t << (4'(r) + 4'd3));
    end
  endfunction

  // Smallest bucket whose block size holds req (req at most 16384).
  function automatic logic [6:0] scba_alloc_bucket(input logic [15:0] req);
    logic [14:0] m;
    logic [14:0] rel;
    logic [2:0]  r;
    m = 15'(req - 16'd1);
    r = 3'd1;
    for (int k = 8; k < 14; k++) begin
      if (m[k]) r = 3'(k - 7);
    end
    rel = m - (15'd128 << r);
    if (req == 16'd0) begin
      scba_alloc_bucket = 7'd0;
    end else if (req <= 16'd256) begin
      scba_alloc_bucket = 7'(m >> 3);
    end else begin
      scba_alloc_bucket = 7'd32 + {r - 3'd1, 4'b0} + 7'(rel >> (4'(r) + 4'd3));
    end
  endfunction

endpackage

@@ design/scba_div.sv @@
// Restoring divider that splits a bucket offset into block index and remainder.
module scba_div
  import scba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [13:0] dividend,
  input  logic [14:0] divisor,
  output logic        busy,
  output logic [13:0] quot,
  output logic [14:0] rem
);

  logic [3:0]  steps;
  logic [13:0] dvd;
  logic [14:0] dsr;
  logic [14:0] trial;

  assign trial = {rem[13:0], dvd[13]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      steps <= 4'd0;
    end else if (start) begin
      busy <= 1'b1;
      steps <= 4'd13;
    end else if (busy) begin
      steps <= steps - 4'd1;
      if (steps == 4'd0) busy <= 1'b0;
    end
  end

  // One quotient bit per cycle, most significant first.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= 15'd0;
      quot <= 14'd0;
    end else if (busy) begin
      dvd <= {dvd[12:0], 1'b0};
      if (trial >= dsr) begin
        rem <= trial - dsr;
        quot <= {quot[12:0], 1'b1};
      end else begin
        rem <= trial;
        quot <= {quot[12:0], 1'b0};
      end
    end
  end

endmodule

@@ design/scba_datapath.sv @@
// Datapath: input latch, free-list memories, divider, address arithmetic and result register.
module scba_datapath
  import scba_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  scba_cmd_t       cmd,
  output scba_sts_t       sts,
  input  logic            cfg_write,
  input  logic [47:0]     cfg_data,
  input  logic            opcode,
  input  logic [15:0]     request_size,
  input  logic [47:0]     free_address,
  output logic [2:0]      status,
  output logic [47:0]     block_address,
  output logic [6:0]      bucket_used
);

  // Head entry: blocks in use, head valid, head link.
  logic [24:0] head_mem [128];
  // Link entry: link valid, link.
  logic [12:0] next_mem [262144];

  logic [47:0] heap_base;
  logic [17:0] clr_cnt;
  logic        is_free;
  logic        too_large;
  logic        out_of_heap;
  logic [6:0]  bkt;
  logic [13:0] off;
  logic [24:0] head_q;
  logic [12:0] next_q;
  logic [26:0] prod;
  logic [47:0] addr_sum;

  logic [47:0] diff;
  logic [14:0] size;
  logic        div_busy;
  logic [13:0] quot;
  logic [14:0] rem;
  logic [15:0] block_end;
  logic [11:0] inuse;
  logic [10:0] clr_blk;
  logic [6:0]  clr_bkt;
  logic [11:0] clr_link;
  logic [27:0] clr_need;
  logic        clr_valid;

  assign diff = free_address - heap_base;
  assign size = scba_block_size(bkt);
  assign inuse = head_q[24:13];
  assign block_end = 16'(off) - 16'(rem) + 16'(size);

  assign clr_blk = clr_cnt[10:0];
  assign clr_bkt = clr_cnt[17:11];
  assign clr_link = 12'(clr_blk) + 12'd1;
  assign clr_need = (28'(clr_blk) + 28'd2) * 28'(scba_block_size(clr_bkt));
  assign clr_valid = clr_need <= 28'd16384;

  assign sts.clear_last = &clr_cnt;
  assign sts.is_free = is_free;
  assign sts.too_large = too_large;
  assign sts.out_of_heap = out_of_heap;
  assign sts.head_valid = head_q[12];
  assign sts.div_busy = div_busy;
  assign sts.block_ok = block_end <= 16'd16384;

  scba_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (off),
    .divisor  (size),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= 48'd0;
      clr_cnt <= 18'd0;
    end else begin
      if (cfg_write) heap_base <= cfg_data;
      if (cmd.clear) clr_cnt <= clr_cnt + 18'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      is_free <= opcode;
      too_large <= request_size > MaxBlockBytes;
      out_of_heap <= (free_address < heap_base) || (diff[47:21] != 27'd0);
      bkt <= opcode ? diff[20:14] : scba_alloc_bucket(request_size);
      off <= diff[13:0];
    end
    if (cmd.mul) prod <= 27'(head_q[10:0]) * 27'(size);
    if (cmd.addr_calc) addr_sum <= heap_base + {27'd0, bkt, 14'd0} + 48'(prod);
    if (cmd.finish) begin
      status <= cmd.code;
      block_address <= (cmd.code == ST_ALLOCATED) ? addr_sum : 48'd0;
      bucket_used <= (cmd.code == ST_TOO_LARGE || cmd.code == ST_NOT_OURS) ? 7'd0 : bkt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.head_rd) head_q <= head_mem[bkt];
    if (cmd.clear && clr_cnt[17:7] == 11'd0) begin
      head_mem[clr_cnt[6:0]] <= {12'd0, 1'b1, 12'd0};
    end else if (cmd.alloc_wr) begin
      head_mem[bkt] <= {inuse + 12'd1, next_q};
    end else if (cmd.free_wr) begin
      head_mem[bkt] <= {(inuse == 12'd0) ? 12'd0 : inuse - 12'd1, 1'b1, 12'(quot[10:0])};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.next_rd) next_q <= next_mem[{bkt, head_q[10:0]}];
    if (cmd.clear) begin
      next_mem[clr_cnt] <= {clr_valid, clr_link};
    end else if (cmd.alloc_wr) begin
      next_mem[{bkt, head_q[10:0]}] <= {1'b0, next_q[11:0]};
    end else if (cmd.free_wr) begin
      next_mem[{bkt, quot[10:0]}] <= head_q[12:0];
    end
  end

endmodule

@@ design/scba_ctrl.sv @@
// Controller state machine that sequences clearing, allocate and free.
module scba_ctrl
  import scba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  scba_sts_t sts,
  output scba_cmd_t cmd,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HEAD = 3'd2;
  localparam logic [2:0] S_ACHK = 3'd3;
  localparam logic [2:0] S_ANEXT = 3'd4;
  localparam logic [2:0] S_AADDR = 3'd5;
  localparam logic [2:0] S_FDIV = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] code;
  logic [2:0] code_next;
  logic       rsp_valid_next;

  assign req_stall = state != S_IDLE;
  assign rsp_valid_next = cmd.finish | (rsp_valid & rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      code <= ST_ALLOCATED;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      code <= code_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.code = code;
    state_next = state;
    code_next = code;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (!sts.is_free && sts.too_large) begin
          code_next = ST_TOO_LARGE;
          state_next = S_DONE;
        end else if (sts.is_free && sts.out_of_heap) begin
          code_next = ST_NOT_OURS;
          state_next = S_DONE;
        end else if (sts.is_free) begin
          cmd.head_rd = 1'b1;
          cmd.div_start = 1'b1;
          state_next = S_FDIV;
        end else begin
          cmd.head_rd = 1'b1;
          state_next = S_ACHK;
        end
      end
      S_ACHK: begin
        if (!sts.head_valid) begin
          code_next = ST_EMPTY;
          state_next = S_DONE;
        end else begin
          cmd.next_rd = 1'b1;
          state_next = S_ANEXT;
        end
      end
      S_ANEXT: begin
        cmd.alloc_wr = 1'b1;
        cmd.mul = 1'b1;
        state_next = S_AADDR;
      end
      S_AADDR: begin
        cmd.addr_calc = 1'b1;
        code_next = ST_ALLOCATED;
        state_next = S_DONE;
      end
      S_FDIV: begin
        if (!sts.div_busy) begin
          if (sts.block_ok) begin
            cmd.free_wr = 1'b1;
            code_next = ST_FREED;
          end else begin
            code_next = ST_NOT_OURS;
          end
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ design/size_class_block_allocator.sv @@
// Top level of the size-class block allocator.
//
//  channel   handshake              payload
//  request   req_valid / req_stall  opcode, request_size, free_address
//  result    rsp_valid / rsp_stall  status, block_address, bucket_used
//  config    cfg_write              cfg_data (heap_base)
//
// After reset a clearing pass fills the link and head memories, one link entry per cycle,
// and no request is taken during it. An allocate reads head, then link, updates the lists
// and sums the address; a free runs the 14-step divider on the bucket offset; too-large,
// outside-heap and empty end early. A transfer may come in the cycle after a result loads.
// A finished result waits in the result register while rsp_stall is high, and the next
// request is taken meanwhile; it only waits at its own end for the register to free up.
module size_class_block_allocator
  import scba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [47:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        opcode,
  input  logic [15:0] request_size,
  input  logic [47:0] free_address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [2:0]  status,
  output logic [47:0] block_address,
  output logic [6:0]  bucket_used
);

  // The controller issues commands and drives the handshakes; the memories and all arithmetic sit in the datapath.
  scba_cmd_t cmd;
  scba_sts_t sts;

  scba_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .opcode        (opcode),
    .request_size  (request_size),
    .free_address  (free_address),
    .status        (status),
    .block_address (block_address),
    .bucket_used   (bucket_used)
  );

  scba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .sts       (sts),
    .cmd       (cmd),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall)
  );

endmodule
